>>> design/easing_curve_interpolator_macros.svh
// Assertion macros for the easing curve interpolator checks
`ifndef EASING_CURVE_INTERPOLATOR_MACROS_SVH
`define EASING_CURVE_INTERPOLATOR_MACROS_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define ECL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ECL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/ecl_pkg.sv
// Shared types, constants and rounding helper for the easing curve interpolator
package ecl_pkg;

  localparam int DATA_W = 16;
  localparam int FRAC   = 12;
  localparam int CH     = 4;
  localparam int A_W    = 20;  // eased weight, signed Q12 with overshoot headroom
  localparam int APB_AW = 2;

  localparam logic [12:0] ONE = 13'd4096;
  localparam logic [14:0] OVERSHOOT_RESET = 15'd6144;
  localparam logic [APB_AW-1:0] ADDR_OVERSHOOT = 2'd0;

  // curve selector codes
  localparam logic [3:0] OP_LINEAR     = 4'd0;
  localparam logic [3:0] OP_SMOOTH     = 4'd1;
  localparam logic [3:0] OP_SMOOTHER   = 4'd2;
  localparam logic [3:0] OP_SINE       = 4'd3;
  localparam logic [3:0] OP_SINE_IN    = 4'd4;
  localparam logic [3:0] OP_SINE_OUT   = 4'd5;
  localparam logic [3:0] OP_CIRCLE_IN  = 4'd6;
  localparam logic [3:0] OP_CIRCLE_OUT = 4'd7;
  localparam logic [3:0] OP_SWING      = 4'd8;
  localparam logic [3:0] OP_SWING_IN   = 4'd9;
  localparam logic [3:0] OP_SWING_OUT  = 4'd10;

  // pipeline stage indices
  localparam int ST_IN     = 0;
  localparam int ST_ALIGN  = 14;  // sine and root results registered here
  localparam int ST_WEIGHT = 15;
  localparam int ST_PROD   = 16;
  localparam int ST_OUT    = 17;
  localparam int NSTG      = 18;

  // sine polynomial constants, Q30
  localparam logic [30:0] PIHALF_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE30      = 31'h4000_0000;

  // floor(v/d) for v < 2^32 as (v*m) >> (32+l), m = ceil(2^(32+l)/d)
  localparam logic [32:0] SIN_RCP [5] = '{
    33'(((64'd1 << 39) + 64'd109) / 64'd110),
    33'(((64'd1 << 39) + 64'd71) / 64'd72),
    33'(((64'd1 << 38) + 64'd41) / 64'd42),
    33'(((64'd1 << 37) + 64'd19) / 64'd20),
    33'(((64'd1 << 35) + 64'd5) / 64'd6)
  };
  localparam int SIN_DSH [5] = '{39, 39, 38, 37, 35};

  typedef logic signed [A_W-1:0]    weight_t;
  typedef logic signed [DATA_W-1:0] sample_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [12:0] p;
  } shape_req_t;

  typedef struct packed {
    logic    clamp;
    sample_t from;
    sample_t to;
  } lane_req_t;

  // round half up, arithmetic
  function automatic logic signed [47:0] rnd_q(input logic signed [47:0] v,
                                               input int unsigned sh);
    rnd_q = (v + (48'sd1 <<< (sh - 1))) >>> sh;
  endfunction

endpackage

>>> design/ecl_if.sv
// Request and result channel interfaces
interface ecl_item_if;
  logic              valid;
  logic              ready;
  logic [3:0]        operation;
  logic [12:0]       progress;
  logic              clamp_nonneg;
  ecl_pkg::sample_t  start_ch0;
  ecl_pkg::sample_t  start_ch1;
  ecl_pkg::sample_t  start_ch2;
  ecl_pkg::sample_t  start_ch3;
  ecl_pkg::sample_t  end_ch0;
  ecl_pkg::sample_t  end_ch1;
  ecl_pkg::sample_t  end_ch2;
  ecl_pkg::sample_t  end_ch3;

  modport source (output valid, operation, progress, clamp_nonneg, start_ch0, start_ch1,
                  start_ch2, start_ch3, end_ch0, end_ch1, end_ch2, end_ch3, input ready);
  modport sink (input valid, operation, progress, clamp_nonneg, start_ch0, start_ch1,
                start_ch2, start_ch3, end_ch0, end_ch1, end_ch2, end_ch3, output ready);
endinterface

interface ecl_result_if;
  logic              valid;
  logic              ready;
  ecl_pkg::sample_t  blend_ch0;
  ecl_pkg::sample_t  blend_ch1;
  ecl_pkg::sample_t  blend_ch2;
  ecl_pkg::sample_t  blend_ch3;

  modport source (output valid, blend_ch0, blend_ch1, blend_ch2, blend_ch3, input ready);
  modport sink (input valid, blend_ch0, blend_ch1, blend_ch2, blend_ch3, output ready);
endinterface

>>> design/easing_curve_interpolator.sv
// Easing curve interpolator top level: input stage, shaper, lanes, output register
//
//  channel   | direction | handshake     | payload
//  ----------+-----------+---------------+------------------------------------------
//  items     | in        | valid/ready   | operation, progress, clamp, 4 start/end
//  results   | out       | valid/ready   | blend_ch0..3
//  apb       | in        | psel/penable  | swing_overshoot at address 0
//
// One request a cycle while the result output is not stalled; the pipe depth is set by
// the sine unit's chain of multiply and reciprocal stages.
// Every stage holds its own valid bit and moves on when the next one is free, so
// bubbles close up and requests are taken while a result waits at the output.
// rst clears the valid bits and loads the overshoot register with 1.5.
module easing_curve_interpolator (
  input  logic                        clk,
  input  logic                        rst,
  ecl_item_if.sink                    items,
  ecl_result_if.source                results,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ecl_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ecl_pkg::*;

  logic [NSTG-1:0] v, en;
  logic [14:0]     overshoot;
  shape_req_t      shape_q;
  lane_req_t       lane_q [CH];
  lane_req_t       lane_in [CH];
  weight_t         weight;
  sample_t         blend [CH];

  // stage moves when empty or when its successor moves
  assign en[NSTG-1] = !v[NSTG-1] || results.ready;
  for (genvar i = 0; i < NSTG - 1; i++) begin : g_en
    assign en[i] = !v[i] || en[i+1];
  end

  assign items.ready = en[ST_IN];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[ST_IN]) v[ST_IN] <= items.valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      overshoot <= OVERSHOOT_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_OVERSHOOT) begin
      overshoot <= pwdata[14:0];
    end
  end

  assign prdata = {17'd0, overshoot};
  assign pready = 1'b1;

  assign lane_in[0] = '{clamp: items.clamp_nonneg, from: items.start_ch0, to: items.end_ch0};
  assign lane_in[1] = '{clamp: items.clamp_nonneg, from: items.start_ch1, to: items.end_ch1};
  assign lane_in[2] = '{clamp: items.clamp_nonneg, from: items.start_ch2, to: items.end_ch2};
  assign lane_in[3] = '{clamp: items.clamp_nonneg, from: items.start_ch3, to: items.end_ch3};

  always_ff @(posedge clk) begin
    if (en[ST_IN]) begin
      shape_q.op <= items.operation;
      shape_q.p  <= (items.progress > ONE) ? ONE : items.progress;
      for (int c = 0; c < CH; c++) lane_q[c] <= lane_in[c];
    end
  end

  ecl_shape u_shape (
    .clk       (clk),
    .en        (en[ST_WEIGHT:1]),
    .req       (shape_q),
    .overshoot (overshoot),
    .weight    (weight)
  );

  for (genvar c = 0; c < CH; c++) begin : g_lane
    ecl_lane u_lane (
      .clk    (clk),
      .en     (en[ST_OUT:1]),
      .req    (lane_q[c]),
      .weight (weight),
      .blend  (blend[c])
    );
  end

  assign results.valid     = v[ST_OUT];
  assign results.blend_ch0 = blend[0];
  assign results.blend_ch1 = blend[1];
  assign results.blend_ch2 = blend[2];
  assign results.blend_ch3 = blend[3];

endmodule

>>> design/ecl_sin.sv
// Pipelined sin(t*pi/2) unit, Q30 Taylor polynomial, Q12 in and out
module ecl_sin (
  input  logic                    clk,
  input  logic [ecl_pkg::ST_ALIGN:1] en,
  input  logic [12:0]             t,
  output logic [12:0]             r
);
  import ecl_pkg::*;

  logic [30:0] z_s  [1:12];
  logic [31:0] z2_s [2:10];
  logic [31:0] m_s  [5];
  logic [29:0] q_s  [5];
  logic [30:0] s_q;
  logic [30:0] h_fin;
  logic [13:0] r_rnd;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      z_s[1] <= 31'((44'(t) * 44'(PIHALF_Q30)) >> 12);
    end
    if (en[2]) begin
      z_s[2]  <= z_s[1];
      z2_s[2] <= 32'((62'(z_s[1]) * 62'(z_s[1])) >> 30);
    end
  end

  // Horner steps: h = 1 - z2*h/d, each a multiply stage then a reciprocal stage
  for (genvar k = 0; k < 5; k++) begin : g_step
    localparam int SA = 3 + 2 * k;
    localparam int SB = 4 + 2 * k;

    always_ff @(posedge clk) begin
      if (en[SA]) begin
        z_s[SA]  <= z_s[SA-1];
      end
    end

    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[SA]) m_s[k] <= z2_s[SA-1];
      end
    end else begin : g_more
      logic [30:0] h;
      assign h = ONE30 - 31'(q_s[k-1]);
      always_ff @(posedge clk) begin
        if (en[SA]) m_s[k] <= 32'((63'(z2_s[SA-1]) * 63'(h)) >> 30);
      end
    end

    always_ff @(posedge clk) begin
      if (en[SB]) begin
        z_s[SB] <= z_s[SB-1];
        q_s[k]  <= 30'((65'(m_s[k]) * 65'(SIN_RCP[k])) >> SIN_DSH[k]);
      end
    end

    // z^2 is only needed up to the last multiply stage
    if (k < 4) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[SA]) z2_s[SA] <= z2_s[SA-1];
        if (en[SB]) z2_s[SB] <= z2_s[SB-1];
      end
    end
  end

  assign h_fin = ONE30 - 31'(q_s[4]);
  assign r_rnd = 14'((s_q + 31'd131072) >> 18);

  always_ff @(posedge clk) begin
    if (en[13]) s_q <= 31'((62'(z_s[12]) * 62'(h_fin)) >> 30);
    if (en[14]) r   <= (r_rnd > 14'(ONE)) ? ONE : r_rnd[12:0];
  end

endmodule

>>> design/ecl_sqrt.sv
// Pipelined floor square root of a 25-bit value, one result bit a stage
module ecl_sqrt (
  input  logic                       clk,
  input  logic [ecl_pkg::ST_ALIGN:1] en,
  input  logic [12:0]                q,
  output logic [12:0]                root
);
  import ecl_pkg::*;

  localparam int STEPS = 13;

  logic [25:0] rem_s [0:STEPS-1];
  logic [25:0] res_s [0:STEPS];

  // radicand 1 - q^2 in Q24
  always_ff @(posedge clk) begin
    if (en[1]) begin
      rem_s[0] <= (26'd1 << 24) - 26'(q) * 26'(q);
      res_s[0] <= '0;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_it
    localparam logic [25:0] BITV = 26'd1 << (24 - 2 * i);
    logic [25:0] trial;
    logic        take;
    assign trial = res_s[i] + BITV;
    assign take  = rem_s[i] >= trial;

    always_ff @(posedge clk) begin
      if (en[2+i]) res_s[i+1] <= take ? ((res_s[i] >> 1) + BITV) : (res_s[i] >> 1);
    end
    if (i < STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[2+i]) rem_s[i+1] <= take ? (rem_s[i] - trial) : rem_s[i];
      end
    end
  end

  assign root = res_s[STEPS][12:0];

endmodule

>>> design/ecl_shape.sv
// Easing curve shaper: polynomial, sine, root and swing curves into one weight
module ecl_shape (
  input  logic                        clk,
  input  logic [ecl_pkg::ST_WEIGHT:1] en,
  input  ecl_pkg::shape_req_t         req,
  input  logic [14:0]                 overshoot,
  output ecl_pkg::weight_t            weight
);
  import ecl_pkg::*;

  logic [12:0] sin_t, sq_arg, sin_r, root;
  logic        sin_neg;
  logic [13:0] p2x;
  logic signed [47:0] ps, xs, sw, sp1;
  logic        sw_plus, sw_hi, sw_ext;

  logic [3:0]  op_d   [1:ST_ALIGN];
  logic        neg_d  [1:ST_ALIGN];
  logic [12:0] p_d    [1:2];
  weight_t     poly_d [3:ST_ALIGN];

  logic [12:0] pp1, sw_x2_1;
  weight_t     pu1, sw_t1;
  logic        sw_hi1, sw_ext1;
  logic [12:0] smooth2, p3_2;
  weight_t     u2, swing2;
  weight_t     poly3;
  logic signed [47:0] pp1w, p1w, x2w, tw, rw, sqw, cw;
  weight_t     weight_next;

  assign p2x = {req.p, 1'b0};

  always_comb begin
    sin_t   = req.p;
    sin_neg = 1'b0;
    case (req.op)
      OP_SINE: begin
        if (p2x <= 14'(ONE)) begin
          sin_t = 13'(14'(ONE) - p2x);
        end else begin
          sin_t   = 13'(p2x - 14'(ONE));
          sin_neg = 1'b1;
        end
      end
      OP_SINE_IN: sin_t = ONE - req.p;
      default:    sin_t = req.p;
    endcase
  end

  assign sq_arg = (req.op == OP_CIRCLE_OUT) ? (ONE - req.p) : req.p;

  // swing: x, sign of the overshoot term, offset of one, extra halving
  assign ps  = signed'(48'(req.p));
  assign sw  = signed'(48'(overshoot));
  assign sp1 = sw + 48'sd4096;

  always_comb begin
    xs      = ps;
    sw_plus = 1'b0;
    sw_hi   = 1'b0;
    sw_ext  = 1'b0;
    case (req.op)
      OP_SWING: begin
        sw_ext = 1'b1;
        if (req.p <= 13'd2048) begin
          xs = ps <<< 1;
        end else begin
          xs      = (ps - 48'sd4096) <<< 1;
          sw_plus = 1'b1;
          sw_hi   = 1'b1;
        end
      end
      OP_SWING_OUT: begin
        xs      = ps - 48'sd4096;
        sw_plus = 1'b1;
        sw_hi   = 1'b1;
      end
      default: xs = ps;
    endcase
  end

  ecl_sin u_sin (
    .clk (clk),
    .en  (en[ST_ALIGN:1]),
    .t   (sin_t),
    .r   (sin_r)
  );

  ecl_sqrt u_sqrt (
    .clk  (clk),
    .en   (en[ST_ALIGN:1]),
    .q    (sq_arg),
    .root (root)
  );

  // stage 1
  always_ff @(posedge clk) begin
    if (en[1]) begin
      op_d[1]  <= req.op;
      neg_d[1] <= sin_neg;
      p_d[1]   <= req.p;
      pp1      <= 13'(rnd_q(ps * ps, FRAC));
      pu1      <= A_W'(rnd_q(ps * ((ps * 48'sd6) - 48'sd61440), FRAC));
      sw_t1    <= A_W'(rnd_q(sp1 * xs, FRAC) + (sw_plus ? sw : -sw));
      sw_x2_1  <= 13'(rnd_q(xs * xs, FRAC));
      sw_hi1   <= sw_hi;
      sw_ext1  <= sw_ext;
    end
  end

  assign pp1w = signed'(48'(pp1));
  assign p1w  = signed'(48'(p_d[1]));
  assign x2w  = signed'(48'(sw_x2_1));
  assign tw   = 48'(sw_t1);

  // stage 2
  always_ff @(posedge clk) begin
    if (en[2]) begin
      op_d[2]  <= op_d[1];
      neg_d[2] <= neg_d[1];
      p_d[2]   <= p_d[1];
      smooth2  <= 13'(rnd_q(pp1w * (48'sd12288 - (p1w <<< 1)), FRAC));
      p3_2     <= 13'(rnd_q(pp1w * p1w, FRAC));
      u2       <= pu1 + A_W'(40960);
      swing2   <= A_W'(rnd_q(x2w * tw, sw_ext1 ? FRAC + 1 : FRAC)
                       + (sw_hi1 ? 48'sd4096 : 48'sd0));
    end
  end

  always_comb begin
    case (op_d[2]) inside
      OP_SMOOTH:   poly3 = A_W'(smooth2);
      OP_SMOOTHER: poly3 = A_W'(rnd_q(signed'(48'(p3_2)) * 48'(u2), FRAC));
      OP_SWING, OP_SWING_IN, OP_SWING_OUT: poly3 = swing2;
      default:     poly3 = A_W'(p_d[2]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      op_d[3]   <= op_d[2];
      neg_d[3]  <= neg_d[2];
      poly_d[3] <= poly3;
    end
    for (int i = 4; i <= ST_ALIGN; i++) begin
      if (en[i]) begin
        op_d[i]   <= op_d[i-1];
        neg_d[i]  <= neg_d[i-1];
        poly_d[i] <= poly_d[i-1];
      end
    end
  end

  assign rw  = signed'(48'(sin_r));
  assign sqw = signed'(48'(root));
  assign cw  = neg_d[ST_ALIGN] ? -rw : rw;

  always_comb begin
    case (op_d[ST_ALIGN])
      OP_SINE:       weight_next = A_W'(rnd_q(48'sd4096 - cw, 1));
      OP_SINE_IN:    weight_next = A_W'(48'sd4096 - rw);
      OP_SINE_OUT:   weight_next = A_W'(rw);
      OP_CIRCLE_IN:  weight_next = A_W'(48'sd4096 - sqw);
      OP_CIRCLE_OUT: weight_next = A_W'(sqw);
      default:       weight_next = poly_d[ST_ALIGN];
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[ST_WEIGHT]) weight <= weight_next;
  end

endmodule

>>> design/ecl_lane.sv
// One channel lane: start + (end - start) * weight, rounded, saturated, optionally clamped at zero
module ecl_lane (
  input  logic                     clk,
  input  logic [ecl_pkg::ST_OUT:1] en,
  input  ecl_pkg::lane_req_t       req,
  input  ecl_pkg::weight_t         weight,
  output ecl_pkg::sample_t         blend
);
  import ecl_pkg::*;

  lane_req_t          req_d [1:ST_WEIGHT];
  logic signed [37:0] prod;
  sample_t            from16;
  logic               clamp16;
  logic signed [47:0] diff, sum;
  sample_t            blend_next;

  always_ff @(posedge clk) begin
    if (en[1]) req_d[1] <= req;
    for (int i = 2; i <= ST_WEIGHT; i++) begin
      if (en[i]) req_d[i] <= req_d[i-1];
    end
  end

  assign diff = 48'(req_d[ST_WEIGHT].to) - 48'(req_d[ST_WEIGHT].from);

  always_ff @(posedge clk) begin
    if (en[ST_PROD]) begin
      prod    <= 38'(diff * 48'(weight));
      from16  <= req_d[ST_WEIGHT].from;
      clamp16 <= req_d[ST_WEIGHT].clamp;
    end
  end

  assign sum = 48'(from16) + rnd_q(48'(prod), FRAC);

  always_comb begin
    if (sum > 48'sd32767) begin
      blend_next = sample_t'(16'sh7FFF);
    end else if (sum < -48'sd32768) begin
      blend_next = sample_t'(16'sh8000);
    end else begin
      blend_next = sample_t'(sum[15:0]);
    end
    if (clamp16 && blend_next[DATA_W-1]) blend_next = '0;
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) blend <= blend_next;
  end

endmodule

>>> design/ecl_checker.sv
// Port-level checks for the easing curve interpolator, bound to the top level
`include "easing_curve_interpolator_macros.svh"

module ecl_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [63:0]                 out_data,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [ecl_pkg::APB_AW-1:0]  paddr,
  input logic [31:0]                 pwdata,
  input logic [31:0]                 prdata
);
  import ecl_pkg::*;

  // a stalled result holds
  `ECL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // requests are refused only when the pipe is full behind a stalled result
  `ECL_ASSERT_NOW(a_ready_backpressure, !in_ready, out_valid && !out_ready, "request refused with room in the pipe")

  // overshoot write reads back
  `ECL_ASSERT_NEXT(a_cfg_readback, psel && penable && pwrite && paddr == ADDR_OVERSHOOT, prdata[14:0] == $past(pwdata[14:0]), "overshoot readback mismatch")

endmodule

bind easing_curve_interpolator ecl_checker u_ecl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (items.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_data  ({results.blend_ch3, results.blend_ch2, results.blend_ch1, results.blend_ch0}),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);

>>> sim/easing_curve_interpolator_tb.sv
// Self-checking testbench for the easing curve interpolator: random requests, scored results
`timescale 1ns / 100ps

module easing_curve_interpolator_tb;
  import ecl_pkg::*;

  localparam logic [3:0] OP_SPARE_LO = 4'd11;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;
  localparam int         DRAIN_CYCLES = 24;
  localparam int         LONG_STALL = 300;

  typedef struct {
    logic [3:0]  op;
    logic [12:0] p;
    logic        clamp;
    sample_t     from [4];
    sample_t     to [4];
  } blend_req_t;

  typedef struct {
    sample_t ch [4];
  } blend_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ecl_item_if   items_if ();
  ecl_result_if res_if ();

  easing_curve_interpolator DUT (
    .clk(clk), .rst(rst), .items(items_if), .results(res_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  blend_req_t pending_reqs [$];
  blend_res_t expected_blends [$];
  blend_req_t cur_req;
  logic [14:0] overshoot_cfg = OVERSHOOT_RESET;
  int errors = 0, n_accepted = 0, n_checked = 0, n_cfg = 0;
  int src_gap = 0, snk_gap = 0, stall_left = 0;
  int stall_asks = 0, stall_done = 0;
  bit calm = 0;

  initial forever #4 clk = ~clk;

  initial begin
    #5ms;
    $display("easing_curve_interpolator_tb: done, errors");
    $finish;
  end

  initial begin
    items_if.valid = 1'b0;
    items_if.operation = '0;
    items_if.progress = '0;
    items_if.clamp_nonneg = 1'b0;
    items_if.start_ch0 = '0; items_if.start_ch1 = '0;
    items_if.start_ch2 = '0; items_if.start_ch3 = '0;
    items_if.end_ch0 = '0; items_if.end_ch1 = '0;
    items_if.end_ch2 = '0; items_if.end_ch3 = '0;
    res_if.ready = 1'b0;
  end

  // ---------------- predictor ----------------
  function automatic longint rnd_half_up(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint sin_quarter_turn(longint t);
    longint unsigned x, z, z2, h, s, r, one30;
    one30 = 64'd1 << 30;
    if (t < 0) t = 0;
    if (t > 4096) t = 4096;
    x = 64'(t) << 18;
    z = (x * 64'(PIHALF_Q30)) >> 30;
    z2 = (z * z) >> 30;
    h = one30 - z2 / 110;
    h = one30 - ((z2 * h) >> 30) / 72;
    h = one30 - ((z2 * h) >> 30) / 42;
    h = one30 - ((z2 * h) >> 30) / 20;
    h = one30 - ((z2 * h) >> 30) / 6;
    s = (z * h) >> 30;
    r = (s + (64'd1 << 17)) >> 18;
    if (r > 4096) r = 4096;
    return longint'(r);
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    for (int i = 0; i < 32; i++) begin
      bitv = 64'd1 << (62 - 2 * i);
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
    end
    return longint'(res);
  endfunction

  function automatic longint swing_poly(longint x, longint s, bit rising, int extra);
    longint t, x2;
    t = rnd_half_up((s + 4096) * x, 12) + (rising ? s : -s);
    x2 = rnd_half_up(x * x, 12);
    return rnd_half_up(x2 * t, 12 + extra);
  endfunction

  function automatic longint eased_weight(logic [3:0] op, longint p, longint s);
    longint one, x, c, p3, u;
    one = 4096;
    case (op)
      OP_SMOOTH:   return rnd_half_up(rnd_half_up(p * p, 12) * (3 * one - 2 * p), 12);
      OP_SMOOTHER: begin
        p3 = rnd_half_up(rnd_half_up(p * p, 12) * p, 12);
        u = rnd_half_up(p * (6 * p - 15 * one), 12) + 10 * one;
        return rnd_half_up(p3 * u, 12);
      end
      OP_SINE: begin
        x = 2 * p;
        c = (x <= one) ? sin_quarter_turn(one - x) : -sin_quarter_turn(x - one);
        return rnd_half_up(one - c, 1);
      end
      OP_SINE_IN:    return one - sin_quarter_turn(one - p);
      OP_SINE_OUT:   return sin_quarter_turn(p);
      OP_CIRCLE_IN:  return one - floor_sqrt(64'(one * one - p * p));
      OP_CIRCLE_OUT: begin
        x = one - p;
        return floor_sqrt(64'(one * one - x * x));
      end
      OP_SWING: begin
        if (p <= one / 2) return swing_poly(2 * p, s, 1'b0, 1);
        return swing_poly(2 * (p - one), s, 1'b1, 1) + one;
      end
      OP_SWING_IN:  return swing_poly(p, s, 1'b0, 0);
      OP_SWING_OUT: return swing_poly(p - one, s, 1'b1, 0) + one;
      default:      return p;
    endcase
  endfunction

  function automatic blend_res_t predict_blend(blend_req_t rq, logic [14:0] ovs);
    blend_res_t res;
    longint p, a, f, t, r;
    p = longint'(rq.p);
    if (p > 4096) p = 4096;
    a = eased_weight(rq.op, p, longint'(ovs));
    for (int k = 0; k < 4; k++) begin
      f = longint'(rq.from[k]);
      t = longint'(rq.to[k]);
      r = f + rnd_half_up((t - f) * a, 12);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      if (rq.clamp && r < 0) r = 0;
      res.ch[k] = sample_t'(r);
    end
    return res;
  endfunction

  // ---------------- request driver ----------------
  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      items_if.valid <= 1'b0;
    end else begin
      if (items_if.valid && items_if.ready) begin
        expected_blends.push_back(predict_blend(cur_req, overshoot_cfg));
        n_accepted++;
      end
      if (!(items_if.valid && !items_if.ready)) begin
        nv = 1'b0;
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          nv = 1'b1;
          items_if.operation <= cur_req.op;
          items_if.progress <= cur_req.p;
          items_if.clamp_nonneg <= cur_req.clamp;
          items_if.start_ch0 <= cur_req.from[0]; items_if.start_ch1 <= cur_req.from[1];
          items_if.start_ch2 <= cur_req.from[2]; items_if.start_ch3 <= cur_req.from[3];
          items_if.end_ch0 <= cur_req.to[0]; items_if.end_ch1 <= cur_req.to[1];
          items_if.end_ch2 <= cur_req.to[2]; items_if.end_ch3 <= cur_req.to[3];
          if (!calm && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 10);
        end
        items_if.valid <= nv;
      end
    end
  end

  // ---------------- result monitor ----------------
  always @(posedge clk) begin
    blend_res_t exp_r;
    sample_t got [4];
    logic nr;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got = '{res_if.blend_ch0, res_if.blend_ch1, res_if.blend_ch2, res_if.blend_ch3};
        if (expected_blends.size() == 0) begin
          $display("%0t: unexpected result %0d %0d %0d %0d", $time,
                   got[0], got[1], got[2], got[3]);
          errors++;
        end else begin
          exp_r = expected_blends.pop_front();
          n_checked++;
          for (int k = 0; k < 4; k++)
            if (got[k] !== exp_r.ch[k]) begin
              $display("%0t: blend_ch%0d expected %0d actual %0d", $time, k,
                       exp_r.ch[k], got[k]);
              errors++;
            end
        end
      end
      nr = 1'b0;
      if (stall_left > 0) begin
        stall_left--;
      end else if (stall_done != stall_asks) begin
        stall_done = stall_asks;
        stall_left = LONG_STALL;
      end else if (snk_gap > 0) begin
        snk_gap--;
      end else begin
        nr = 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) snk_gap = $urandom_range(1, 10);
      end
      res_if.ready <= nr;
    end
  end

  // ---------------- stimulus ----------------
  function automatic sample_t pick_value();
    case ($urandom_range(0, 9))
      0:       return sample_t'(16'h8000);
      1:       return sample_t'(16'h7FFF);
      2:       return '0;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic blend_req_t random_req();
    blend_req_t rq;
    rq.op = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI))
                                         : 4'($urandom_range(OP_LINEAR, OP_SWING_OUT));
    case ($urandom_range(0, 9))
      0:       rq.p = '0;
      1:       rq.p = ONE;
      2:       rq.p = 13'($urandom_range(4097, 8191));
      default: rq.p = 13'($urandom_range(0, 4096));
    endcase
    rq.clamp = 1'($urandom_range(0, 1));
    for (int k = 0; k < 4; k++) begin
      rq.from[k] = pick_value();
      rq.to[k] = pick_value();
    end
    return rq;
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || items_if.valid || expected_blends.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_overshoot(logic [14:0] v);
    wait_idle();
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_OVERSHOOT; pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    overshoot_cfg = v;
    n_cfg++;
    @(negedge clk);
    if (prdata[14:0] !== v) begin
      $display("%0t: overshoot readback expected %0d actual %0d", $time, v, prdata[14:0]);
      errors++;
    end
  endtask

  task automatic queue_random(int n);
    @(negedge clk);
    repeat (n) pending_reqs.push_back(random_req());
  endtask

  initial begin
    blend_req_t rq;
    logic [12:0] p_pts [5] = '{13'd0, 13'd1024, 13'd2048, 13'd4096, 13'd8191};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // every selector, progress at the ends and past one, extreme channel values
    for (int op = 0; op < 16; op++) begin
      rq.op = 4'(op);
      rq.p = p_pts[op % 5];
      rq.clamp = op[0];
      for (int k = 0; k < 4; k++) begin
        rq.from[k] = (k[0] ^ op[1]) ? sample_t'(16'h8000) : sample_t'(16'h7FFF);
        rq.to[k] = -rq.from[k] - 1;
      end
      pending_reqs.push_back(rq);
    end
    for (int j = 0; j < 4; j++) begin
      rq.op = (j < 2) ? OP_SWING_IN : OP_SWING_OUT;
      rq.p = p_pts[j + 1];
      rq.clamp = j[0];
      for (int k = 0; k < 4; k++) begin
        rq.from[k] = sample_t'(16'h8000);
        rq.to[k] = sample_t'(16'h7FFF);
      end
      pending_reqs.push_back(rq);
    end
    write_overshoot(15'd16384);
    queue_random(250);
    write_overshoot(15'd0);
    queue_random(250);
    stall_asks = stall_asks + 1;  // long hold-off while requests keep coming
    write_overshoot(15'd32767);
    queue_random(200);
    write_overshoot(15'($urandom_range(0, 32767)));
    queue_random(200);
    write_overshoot(OVERSHOOT_RESET);
    @(negedge clk);
    calm = 1;
    queue_random(200);
    do @(negedge clk);
    while (pending_reqs.size() != 0 || items_if.valid || expected_blends.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d requests, %0d results checked, %0d overshoot settings",
             n_accepted, n_checked, n_cfg);
    if (errors == 0)
      $display("easing_curve_interpolator_tb: done, clean");
    else
      $display("easing_curve_interpolator_tb: done, errors");
    $finish;
  end

endmodule
